>>> src/rotated_volume_trilinear_sampler_defines.svh
// assertion macros for the volume sampler
`ifndef ROTATED_VOLUME_TRILINEAR_SAMPLER_DEFINES_SVH
`define ROTATED_VOLUME_TRILINEAR_SAMPLER_DEFINES_SVH

`define RVTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define RVTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rvts_pkg.sv
package rvts_pkg;
   localparam int DIM_BITS_DEF = 6;
   localparam int VOXEL_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 14;
   localparam int COEF_BITS = 16;
   localparam int ROW_BITS = 3 * COEF_BITS;
   localparam int RESET_CENTRE = 25;
   localparam int RESET_EXTENT = 51;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = ROW_BITS;

   localparam logic [CSR_IDX_BITS-1:0] REG_ROT_ROW0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROT_ROW1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROT_ROW2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTER = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_EXTENT_X = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_EXTENT_Y = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_EXTENT_Z = 3'd6;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;
endpackage

>>> src/rvts_bank.sv
module rvts_bank #(
   parameter int ADDR_BITS = 15,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);
   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> src/rvts_lerp.sv
module rvts_lerp #(
   parameter int VOXEL_BITS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [VOXEL_BITS-1:0] a,
   input  logic [VOXEL_BITS-1:0] b,
   input  logic [FRAC_BITS-1:0]  f,
   output logic [VOXEL_BITS-1:0] y
);
   localparam int PW = VOXEL_BITS + FRAC_BITS + 1;
   logic [PW-1:0] sum;
   logic [FRAC_BITS:0] fb;

   always_comb begin
      fb = (FRAC_BITS+1)'(1) << FRAC_BITS;
      fb = fb - {1'b0, f};
      sum = PW'(a) * PW'(fb) + PW'(b) * PW'(f);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         y <= sum[FRAC_BITS +: VOXEL_BITS];
      end
   end
endmodule

>>> src/rotated_volume_trilinear_sampler.sv
// rotated volume trilinear sampler
// req channel: command 0 writes voxel_value at (x,y,z), command 1 samples the
// volume rotated by the inverse matrix about the configured centre.
// rsp channel: one beat per sample (sample_value, in_range), none per write.
// csr port: plain writes of the seven registers, to be made by the user only while idle (not enforced).
// throughput: one beat per cycle while the pipeline is not halted; the volume sits
// in eight banks split by coordinate parity, so all eight neighbours are read together.
// pipeline: 3 rotation stages, bank read, x, y and z interpolation stages and
// output register.
// the whole pipeline advances together; it halts while rsp_stall holds a
// valid output, and req_stall is raised then. writes travel down the pipe
// and land in the banks at the bank read stage, so each sample sees exactly
// the writes accepted before it.
// reset clears all valid flags and loads the default registers; the voxel
// contents are undefined until written and no clearing pass is made.
module rotated_volume_trilinear_sampler #(
   parameter int DIM_BITS = rvts_pkg::DIM_BITS_DEF,
   parameter int VOXEL_BITS = rvts_pkg::VOXEL_BITS_DEF,
   parameter int FRAC_BITS = rvts_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [DIM_BITS-1:0]                req_x_coord,
   input  logic [DIM_BITS-1:0]                req_y_coord,
   input  logic [DIM_BITS-1:0]                req_z_coord,
   input  logic [VOXEL_BITS-1:0]              req_voxel_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [VOXEL_BITS-1:0]              rsp_sample_value,
   output logic                               rsp_in_range,
   input  logic                               csr_write,
   input  logic [rvts_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rvts_pkg::CSR_DATA_BITS-1:0] csr_data
);
`include "rotated_volume_trilinear_sampler_defines.svh"

   localparam int CB = rvts_pkg::COEF_BITS;
   localparam int DB = DIM_BITS + 1;
   localparam int PB = CB + DB;
   localparam int AB = PB + 3;
   localparam int HB = DIM_BITS - 1;
   localparam int BA = 3 * HB;
   localparam int NST = 8;

   typedef struct packed {
      logic [DIM_BITS-1:0] x;
      logic [DIM_BITS-1:0] y;
      logic [DIM_BITS-1:0] z;
   } vec_type;

   logic [rvts_pkg::ROW_BITS-1:0] rot_ff [3];
   logic [3*DIM_BITS-1:0] center_ff;
   logic [DIM_BITS:0] ext_ff [3];

   logic adv;
   logic [NST-1:0] v_ff;

   always_comb begin
      adv = !(v_ff[NST-1] && rsp_stall);
      req_stall = !adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= rvts_pkg::ROW_BITS'(1 << FRAC_BITS);
         rot_ff[1] <= rvts_pkg::ROW_BITS'(1 << FRAC_BITS) << CB;
         rot_ff[2] <= rvts_pkg::ROW_BITS'(1 << FRAC_BITS) << (2 * CB);
         center_ff <= {3{DIM_BITS'(rvts_pkg::RESET_CENTRE)}};
         for (int i = 0; i < 3; i++) begin
            ext_ff[i] <= (DIM_BITS+1)'(rvts_pkg::RESET_EXTENT);
         end
      end else if (csr_write) begin
         unique case (csr_index)
            rvts_pkg::REG_ROT_ROW0: rot_ff[0] <= csr_data;
            rvts_pkg::REG_ROT_ROW1: rot_ff[1] <= csr_data;
            rvts_pkg::REG_ROT_ROW2: rot_ff[2] <= csr_data;
            rvts_pkg::REG_CENTER: center_ff <= csr_data[3*DIM_BITS-1:0];
            rvts_pkg::REG_EXTENT_X: ext_ff[0] <= csr_data[DIM_BITS:0];
            rvts_pkg::REG_EXTENT_Y: ext_ff[1] <= csr_data[DIM_BITS:0];
            rvts_pkg::REG_EXTENT_Z: ext_ff[2] <= csr_data[DIM_BITS:0];
            default: ;
         endcase
      end
   end

   // valid chain
   logic [NST-1:0] v_in;
   always_comb begin
      v_in = {v_ff[NST-2:0], req_valid && req_command == rvts_pkg::CMD_SAMPLE};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // stage 1: differences
   logic signed [DB-1:0] d_ff [3];
   logic [DIM_BITS-1:0] c_ff [3];
   logic [DIM_BITS-1:0] pin [3];
   always_comb begin
      pin[0] = req_x_coord;
      pin[1] = req_y_coord;
      pin[2] = req_z_coord;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            c_ff[k] <= center_ff[k*DIM_BITS +: DIM_BITS];
            d_ff[k] <= $signed({1'b0, pin[k]})
               - $signed({1'b0, center_ff[k*DIM_BITS +: DIM_BITS]});
         end
      end
   end

   // stage 2: products
   logic signed [PB-1:0] p_ff [3][3];
   logic [DIM_BITS-1:0] c2_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            c2_ff[r] <= c_ff[r];
            for (int k = 0; k < 3; k++) begin
               p_ff[r][k] <= PB'($signed(rot_ff[r][k*CB +: CB]) * d_ff[k]);
            end
         end
      end
   end

   // stage 3: sums, floor, range
   logic signed [AB-1:0] acc [3];
   logic signed [AB-FRAC_BITS-1:0] fl [3];
   logic [DIM_BITS:0] ex [3];
   logic ok;
   logic ok_ff;
   logic [DIM_BITS-1:0] base_ff [3];
   logic [FRAC_BITS-1:0] fr_ff [3];
   always_comb begin
      ok = 1'b1;
      for (int r = 0; r < 3; r++) begin
         acc[r] = AB'(p_ff[r][0]) + AB'(p_ff[r][1]) + AB'(p_ff[r][2])
            + $signed({{(AB-DIM_BITS-FRAC_BITS){1'b0}}, c2_ff[r], {FRAC_BITS{1'b0}}});
         fl[r] = acc[r][AB-1:FRAC_BITS];
         ex[r] = ext_ff[r] > (DIM_BITS+1)'(1 << DIM_BITS)
            ? (DIM_BITS+1)'(1 << DIM_BITS) : ext_ff[r];
         if (fl[r] < 0 || fl[r] + 1 >= $signed({1'b0, ex[r]})) begin
            ok = 1'b0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff <= ok;
         for (int r = 0; r < 3; r++) begin
            base_ff[r] <= fl[r][DIM_BITS-1:0];
            fr_ff[r] <= acc[r][FRAC_BITS-1:0];
         end
      end
   end

   // write beats follow the pipe to the bank read stage
   logic [2:0] wr_ff;
   logic [2:0] wr_in;
   vec_type wpos_ff [3];
   logic [VOXEL_BITS-1:0] wdat_ff [3];
   always_comb begin
      wr_in = {wr_ff[1:0], req_valid && req_command == rvts_pkg::CMD_WRITE};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
      end else if (adv) begin
         wr_ff <= wr_in;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         wpos_ff[0] <= {req_x_coord, req_y_coord, req_z_coord};
         wdat_ff[0] <= req_voxel_value;
         for (int i = 1; i < 3; i++) begin
            wpos_ff[i] <= wpos_ff[i-1];
            wdat_ff[i] <= wdat_ff[i-1];
         end
      end
   end

   // banks: bank index = parity of x,y,z; address = halves
   logic [HB-1:0] lo [3];
   logic [HB-1:0] hi [3];
   logic [VOXEL_BITS-1:0] rd [8];
   logic wr;
   always_comb begin
      wr = adv && wr_ff[2];
      for (int k = 0; k < 3; k++) begin
         lo[k] = base_ff[k][DIM_BITS-1:1] + HB'(base_ff[k][0]);
         hi[k] = base_ff[k][DIM_BITS-1:1];
      end
   end

   for (genvar b = 0; b < 8; b++) begin : g_bank
      logic [BA-1:0] ra;
      logic [BA-1:0] wa;
      logic we;
      always_comb begin
         ra = {(b[2] ? hi[2] : lo[2]), (b[1] ? hi[1] : lo[1]), (b[0] ? hi[0] : lo[0])};
         wa = {wpos_ff[2].z[DIM_BITS-1:1], wpos_ff[2].y[DIM_BITS-1:1],
               wpos_ff[2].x[DIM_BITS-1:1]};
         we = wr && wpos_ff[2].x[0] == b[0] && wpos_ff[2].y[0] == b[1]
            && wpos_ff[2].z[0] == b[2];
      end
      rvts_bank #(.ADDR_BITS(BA), .DATA_BITS(VOXEL_BITS)) u_bank (
         .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wdat_ff[2]),
         .rd_en(adv), .rd_addr(ra), .rd_data(rd[b])
      );
   end

   // stage 4 and later metadata
   logic [2:0] par_ff;
   logic ok4_ff, ok5_ff, ok6_ff, ok7_ff;
   logic [FRAC_BITS-1:0] fy4_ff, fz4_ff, fz5_ff;
   logic [FRAC_BITS-1:0] fx4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         par_ff <= {base_ff[2][0], base_ff[1][0], base_ff[0][0]};
         ok4_ff <= ok_ff;
         fx4_ff <= fr_ff[0];
         fy4_ff <= fr_ff[1];
         fz4_ff <= fr_ff[2];
         ok5_ff <= ok4_ff;
         fz5_ff <= fz4_ff;
         ok6_ff <= ok5_ff;
         ok7_ff <= ok6_ff;
      end
   end

   // neighbor n (bits zyx offset) lives in bank n ^ parity
   logic [VOXEL_BITS-1:0] nb [8];
   always_comb begin
      for (int n = 0; n < 8; n++) begin
         nb[n] = rd[3'(n) ^ par_ff];
      end
   end

   logic [VOXEL_BITS-1:0] ax [4];
   for (genvar j = 0; j < 4; j++) begin : g_lx
      rvts_lerp #(.VOXEL_BITS(VOXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_lx (
         .clock(clock), .enable(adv), .a(nb[2*j]), .b(nb[2*j+1]), .f(fx4_ff), .y(ax[j])
      );
   end
   logic [FRAC_BITS-1:0] fy5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fy5_ff <= fy4_ff;
      end
   end
   logic [VOXEL_BITS-1:0] by [2];
   for (genvar j = 0; j < 2; j++) begin : g_ly
      rvts_lerp #(.VOXEL_BITS(VOXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_ly (
         .clock(clock), .enable(adv), .a(ax[2*j]), .b(ax[2*j+1]), .f(fy5_ff), .y(by[j])
      );
   end
   logic [FRAC_BITS-1:0] fz6_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fz6_ff <= fz5_ff;
      end
   end
   logic [VOXEL_BITS-1:0] cz;
   rvts_lerp #(.VOXEL_BITS(VOXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_lz (
      .clock(clock), .enable(adv), .a(by[0]), .b(by[1]), .f(fz6_ff), .y(cz)
   );

   // output register
   logic [VOXEL_BITS-1:0] out_ff;
   logic rng_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= ok7_ff ? cz : '0;
         rng_ff <= ok7_ff;
      end
   end

   assign rsp_valid = v_ff[NST-1];
   assign rsp_sample_value = out_ff;
   assign rsp_in_range = rng_ff;

   `RVTS_ASSERT_IMPL(a_range_zero, clock, reset, rsp_valid && !rsp_in_range, rsp_sample_value == '0, "out of range beat carries data")
   `RVTS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_value), "stalled beat changed")
   `RVTS_ASSERT_IMPL(a_stall, clock, reset, rsp_valid && rsp_stall, req_stall, "accepting while output blocked")
endmodule
